/* rtl/core/ansi_escape_color_parser_unit_macros.svh */
// ----------------------------------------------------------------------------
// ansi escape color parser assertion macros
// shared property forms for the parser checks
// ----------------------------------------------------------------------------
`ifndef ANSI_ESCAPE_COLOR_PARSER_UNIT_MACROS_SVH
`define ANSI_ESCAPE_COLOR_PARSER_UNIT_MACROS_SVH

// same-cycle implication
`define AECP_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) \
        (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define AECP_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) \
        (ante) |=> (cons)) else $error(msg);

`endif

/* rtl/core/aecp_pkg.sv */
// ----------------------------------------------------------------------------
// aecp_pkg
// types, codes and color table of the ansi escape color parser
// ----------------------------------------------------------------------------
package aecp_pkg;

    localparam int DIGIT_W = 4;

    localparam logic [7:0] CH_ESC    = 8'h1B;
    localparam logic [7:0] CH_LBRACK = 8'h5B;
    localparam logic [7:0] CH_M      = 8'h6D;
    localparam logic [7:0] CH_J      = 8'h4A;
    localparam logic [7:0] CH_ZERO   = 8'h30;
    localparam logic [7:0] CH_NINE   = 8'h39;
    localparam logic [7:0] CH_NUL    = 8'h00;

    localparam logic [7:0] SGR_RESET    = 8'd0;
    localparam logic [7:0] SGR_FG_LO    = 8'd30;
    localparam logic [7:0] SGR_FG_HI    = 8'd37;
    localparam logic [7:0] SGR_FG_DEF   = 8'd39;
    localparam logic [7:0] SGR_BG_LO    = 8'd40;
    localparam logic [7:0] SGR_BG_HI    = 8'd47;
    localparam logic [7:0] SGR_BG_DEF   = 8'd49;
    localparam logic [7:0] SGR_FGB_LO   = 8'd90;
    localparam logic [7:0] SGR_FGB_HI   = 8'd97;
    localparam logic [7:0] ED_ALL       = 8'd2;
    localparam logic [7:0] PARAM_SAT    = 8'd255;

    localparam logic [3:0] FG_RESET = 4'd7;
    localparam logic [3:0] BG_RESET = 4'd0;

    typedef enum logic [3:0] {
        MODE_TEXT    = 4'b0001,
        MODE_ESC     = 4'b0010,
        MODE_PARAM   = 4'b0100,
        MODE_DISCARD = 4'b1000
    } aecp_mode_t;

    typedef enum logic [1:0] {
        ACT_PUTC  = 2'd0,
        ACT_COLOR = 2'd1,
        ACT_CLEAR = 2'd2
    } aecp_action_t;

    typedef struct packed {
        logic [7:0] in_byte;
        logic       end_of_buffer;
    } aecp_in_t;

    typedef struct packed {
        aecp_action_t action;
        logic [7:0]   char_out;
        logic [3:0]   fg_color;
        logic [3:0]   bg_color;
        logic         last_result;
    } aecp_out_t;

    typedef struct packed {
        aecp_mode_t         mode;
        logic [DIGIT_W-1:0] digit_count;
        logic [7:0]         param_value;
        logic [3:0]         fg;
        logic [3:0]         bg;
    } aecp_state_t;

    typedef struct packed {
        logic [1:0] count;
        aecp_out_t  res0;
        aecp_out_t  res1;
    } aecp_emit_t;

    // ansi color order to vga numbering
    function automatic logic [2:0] ansi_to_vga(input logic [2:0] idx);
        logic [2:0] vga;
        case (idx)
            3'd0:    vga = 3'd0;
            3'd1:    vga = 3'd4;
            3'd2:    vga = 3'd2;
            3'd3:    vga = 3'd6;
            3'd4:    vga = 3'd1;
            3'd5:    vga = 3'd5;
            3'd6:    vga = 3'd3;
            default: vga = 3'd7;
        endcase
        return vga;
    endfunction

endpackage

/* rtl/core/ansi_escape_color_parser_unit.sv */
// ----------------------------------------------------------------------------
// ansi_escape_color_parser_unit: csi/sgr escape parser for a 16-color console
// datapath: a byte is registered in the input stage, its result beats in the output register
// throughput: one byte per cycle, stalled by m_ready; a two-result byte holds the input stage
// reset: aresetn low clears all stages, text mode, colors 7 on 0
// ----------------------------------------------------------------------------
`include "ansi_escape_color_parser_unit_macros.svh"

module ansi_escape_color_parser_unit
    import aecp_pkg::*;
#(
    parameter int MAX_DIGITS = 15
) (
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      s_valid,
    output logic      s_ready,
    input  aecp_in_t  s_data,
    output logic      m_valid,
    input  logic      m_ready,
    output aecp_out_t m_data
);

    aecp_state_t state_reg;
    aecp_state_t state_next;
    logic        in_valid_reg;
    aecp_in_t    in_beat_reg;
    logic        m_valid_reg;
    aecp_out_t   m_beat_reg;
    logic        pend_valid_reg;
    aecp_out_t   pend_beat_reg;
    aecp_emit_t  emit;
    logic        stage_fire;
    logic        s_fire;
    logic        m_fire;

    aecp_decode #(
        .MAX_DIGITS(MAX_DIGITS)
    ) u_decode (
        .cur (state_reg),
        .beat(in_beat_reg),
        .nxt (state_next),
        .emit(emit)
    );

    assign m_fire     = m_valid_reg && m_ready;
    assign stage_fire = in_valid_reg && !pend_valid_reg && (!m_valid_reg || m_ready);
    assign s_ready    = !in_valid_reg || stage_fire;
    assign s_fire     = s_valid && s_ready;
    assign m_valid    = m_valid_reg;
    assign m_data     = m_beat_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_ready) begin
            in_valid_reg <= s_valid;
        end
        if (s_fire) begin
            in_beat_reg <= s_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= '{mode: MODE_TEXT, digit_count: '0, param_value: 8'd0,
                           fg: FG_RESET, bg: BG_RESET};
        end else if (stage_fire) begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg    <= 1'b0;
            pend_valid_reg <= 1'b0;
        end else if (stage_fire && (emit.count != 2'd0)) begin
            m_valid_reg    <= 1'b1;
            m_beat_reg     <= emit.res0;
            pend_valid_reg <= (emit.count == 2'd2);
            pend_beat_reg  <= emit.res1;
        end else if (m_fire) begin
            if (pend_valid_reg) begin
                m_beat_reg     <= pend_beat_reg;
                pend_valid_reg <= 1'b0;
            end else begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    `AECP_ASSERT_SAME(a_pend_behind_out, pend_valid_reg, m_valid_reg,
        "second beat pending without a held result")
    `AECP_ASSERT_NEXT(a_two_beats_pend, stage_fire && (emit.count == 2'd2),
        pend_valid_reg && m_valid_reg, "double result not split over two beats")
    `AECP_ASSERT_SAME(a_char_zero, m_valid_reg && (m_beat_reg.action != ACT_PUTC),
        m_beat_reg.char_out == 8'd0, "non-character beat carries a character")
    `AECP_ASSERT_SAME(a_digit_bound, in_valid_reg,
        state_reg.digit_count <= 4'(MAX_DIGITS), "digit count past its limit")

endmodule

/* rtl/core/aecp_decode.sv */
// ----------------------------------------------------------------------------
// aecp_decode
// next parse state and up to two result beats for one input byte
// ----------------------------------------------------------------------------
module aecp_decode
    import aecp_pkg::*;
#(
    parameter int MAX_DIGITS = 15
) (
    input  aecp_state_t cur,
    input  aecp_in_t    beat,
    output aecp_state_t nxt,
    output aecp_emit_t  emit
);

    logic [7:0]  c;
    logic        eob;
    logic        txt_emit;
    aecp_mode_t  txt_mode;
    logic        is_digit;
    logic [3:0]  digit_val;
    logic [11:0] acc;
    logic [7:0]  sgr_off;
    aecp_out_t   blank;

    assign c         = beat.in_byte;
    assign eob       = beat.end_of_buffer;
    assign txt_emit  = (c != CH_NUL) && ((c != CH_ESC) || eob);
    assign is_digit  = (c >= CH_ZERO) && (c <= CH_NINE);
    assign digit_val = 4'(c - CH_ZERO);
    assign acc       = 12'(cur.param_value) * 12'd10 + 12'(digit_val);

    always_comb begin
        if (c == CH_NUL) begin
            txt_mode = MODE_DISCARD;
        end else if ((c == CH_ESC) && !eob) begin
            txt_mode = MODE_ESC;
        end else begin
            txt_mode = MODE_TEXT;
        end
    end

    always_comb begin
        blank = '{action: ACT_PUTC, char_out: 8'd0, fg_color: 4'd0,
                  bg_color: 4'd0, last_result: 1'b0};
        nxt        = cur;
        emit.count = 2'd0;
        emit.res0  = blank;
        emit.res1  = blank;
        sgr_off    = 8'd0;

        unique case (cur.mode)
            MODE_TEXT: begin
                if (txt_emit) begin
                    emit.count         = 2'd1;
                    emit.res0.char_out = c;
                end
                nxt.mode = txt_mode;
            end
            MODE_ESC: begin
                if (c == CH_LBRACK) begin
                    nxt.mode        = MODE_PARAM;
                    nxt.digit_count = '0;
                    nxt.param_value = 8'd0;
                end else begin
                    emit.res0.char_out = CH_ESC;
                    emit.res1.char_out = c;
                    emit.count         = txt_emit ? 2'd2 : 2'd1;
                    nxt.mode           = txt_mode;
                end
            end
            MODE_PARAM: begin
                if ((cur.digit_count < DIGIT_W'(MAX_DIGITS)) && is_digit) begin
                    nxt.param_value = (acc > 12'(PARAM_SAT)) ? PARAM_SAT : acc[7:0];
                    nxt.digit_count = cur.digit_count + DIGIT_W'(1);
                end else begin
                    if (c == CH_M) begin
                        emit.count       = 2'd1;
                        emit.res0.action = ACT_COLOR;
                        case (cur.param_value) inside
                            SGR_RESET: begin
                                nxt.fg = FG_RESET;
                                nxt.bg = BG_RESET;
                            end
                            [SGR_FG_LO:SGR_FG_HI]: begin
                                sgr_off = cur.param_value - SGR_FG_LO;
                                nxt.fg  = {1'b0, ansi_to_vga(sgr_off[2:0])};
                            end
                            SGR_FG_DEF: begin
                                nxt.fg = FG_RESET;
                            end
                            [SGR_BG_LO:SGR_BG_HI]: begin
                                sgr_off = cur.param_value - SGR_BG_LO;
                                nxt.bg  = {1'b0, ansi_to_vga(sgr_off[2:0])};
                            end
                            SGR_BG_DEF: begin
                                nxt.bg = BG_RESET;
                            end
                            [SGR_FGB_LO:SGR_FGB_HI]: begin
                                sgr_off = cur.param_value - SGR_FGB_LO;
                                nxt.fg  = {1'b1, ansi_to_vga(sgr_off[2:0])};
                            end
                            default: begin
                            end
                        endcase
                    end else if ((c == CH_J) && (cur.param_value == ED_ALL)) begin
                        emit.count       = 2'd1;
                        emit.res0.action = ACT_CLEAR;
                    end
                    nxt.mode        = MODE_TEXT;
                    nxt.digit_count = '0;
                    nxt.param_value = 8'd0;
                end
            end
            MODE_DISCARD: begin
            end
            default: begin
                nxt.mode = MODE_TEXT;
            end
        endcase

        if (eob) begin
            nxt.mode        = MODE_TEXT;
            nxt.digit_count = '0;
            nxt.param_value = 8'd0;
        end

        emit.res0.fg_color    = nxt.fg;
        emit.res0.bg_color    = nxt.bg;
        emit.res0.last_result = (emit.count == 2'd1);
        emit.res1.fg_color    = nxt.fg;
        emit.res1.bg_color    = nxt.bg;
        emit.res1.last_result = 1'b1;
    end

endmodule

/* dv/aecp_console_checker.sv */
// ----------------------------------------------------------------------------
// aecp_console_checker
// Watches both channels of the escape parser. For every input beat it works
// out the console operations the parser should emit, then compares each
// result beat field by field against the oldest one still waiting.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module aecp_console_checker
    import aecp_pkg::*;
#(
    parameter int MAX_DIGITS = 15
) (
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      s_valid,
    input  logic      s_ready,
    input  aecp_in_t  s_data,
    input  logic      m_valid,
    input  logic      m_ready,
    input  aecp_out_t m_data,
    output int        fail_count,
    output int        pending
);

    // ansi color index to vga color, three bits per entry
    localparam logic [23:0] VGA_ORDER = {3'd7, 3'd3, 3'd5, 3'd1, 3'd6, 3'd2, 3'd4, 3'd0};

    aecp_mode_t  parse_mode;
    logic [3:0]  digit_cnt;
    logic [7:0]  param_val;
    logic [3:0]  fg_now;
    logic [3:0]  bg_now;

    aecp_out_t   byte_ops[$];
    aecp_out_t   console_ops_q[$];

    function automatic logic [2:0] vga_of(input logic [7:0] offset);
        return VGA_ORDER[3 * offset[2:0] +: 3];
    endfunction

    task automatic push_op(input aecp_action_t act, input logic [7:0] ch);
        aecp_out_t op;
        op.action      = act;
        op.char_out    = ch;
        op.fg_color    = fg_now;
        op.bg_color    = bg_now;
        op.last_result = 1'b0;
        byte_ops.push_back(op);
    endtask

    task automatic take_text_byte(input logic [7:0] c, input logic eob);
        if (c == CH_NUL) begin
            parse_mode = MODE_DISCARD;
        end else if (c == CH_ESC) begin
            if (eob) begin
                push_op(ACT_PUTC, CH_ESC);
            end else begin
                parse_mode = MODE_ESC;
            end
        end else begin
            push_op(ACT_PUTC, c);
        end
    endtask

    task automatic apply_sgr_code(input logic [7:0] code);
        if (code == SGR_RESET) begin
            fg_now = FG_RESET;
            bg_now = BG_RESET;
        end else if (code >= SGR_FG_LO && code <= SGR_FG_HI) begin
            fg_now = {1'b0, vga_of(code - SGR_FG_LO)};
        end else if (code == SGR_FG_DEF) begin
            fg_now = FG_RESET;
        end else if (code >= SGR_BG_LO && code <= SGR_BG_HI) begin
            bg_now = {1'b0, vga_of(code - SGR_BG_LO)};
        end else if (code == SGR_BG_DEF) begin
            bg_now = BG_RESET;
        end else if (code >= SGR_FGB_LO && code <= SGR_FGB_HI) begin
            fg_now = {1'b1, vga_of(code - SGR_FGB_LO)};
        end
    endtask

    task automatic predict_console_ops(input aecp_in_t beat);
        logic [7:0]  c;
        logic        eob;
        int unsigned acc;
        c   = beat.in_byte;
        eob = beat.end_of_buffer;
        byte_ops = {};
        case (parse_mode)
            MODE_TEXT: begin
                take_text_byte(c, eob);
            end
            MODE_ESC: begin
                if (c == CH_LBRACK) begin
                    parse_mode = MODE_PARAM;
                    digit_cnt  = '0;
                    param_val  = '0;
                end else begin
                    push_op(ACT_PUTC, CH_ESC);
                    parse_mode = MODE_TEXT;
                    take_text_byte(c, eob);
                end
            end
            MODE_PARAM: begin
                if (digit_cnt < MAX_DIGITS && c >= CH_ZERO && c <= CH_NINE) begin
                    acc       = param_val * 10 + (c - CH_ZERO);
                    param_val = (acc > 255) ? PARAM_SAT : acc[7:0];
                    digit_cnt = digit_cnt + 4'd1;
                end else begin
                    if (c == CH_M) begin
                        apply_sgr_code(param_val);
                        push_op(ACT_COLOR, 8'h00);
                    end else if (c == CH_J && param_val == ED_ALL) begin
                        push_op(ACT_CLEAR, 8'h00);
                    end
                    parse_mode = MODE_TEXT;
                    digit_cnt  = '0;
                    param_val  = '0;
                end
            end
            default: ;
        endcase
        if (eob) begin
            parse_mode = MODE_TEXT;
            digit_cnt  = '0;
            param_val  = '0;
        end
        if (byte_ops.size() > 0) begin
            byte_ops[byte_ops.size() - 1].last_result = 1'b1;
        end
        foreach (byte_ops[i]) begin
            console_ops_q.push_back(byte_ops[i]);
        end
    endtask

    task automatic check_console_op(input aecp_out_t got);
        aecp_out_t want;
        if (console_ops_q.size() == 0) begin
            $error("unexpected result beat: action %0d char %02h", got.action, got.char_out);
            fail_count++;
        end else begin
            want = console_ops_q.pop_front();
            if (got.action !== want.action) begin
                $error("action: expected %0d, got %0d", want.action, got.action);
                fail_count++;
            end
            if (got.char_out !== want.char_out) begin
                $error("char_out: expected %02h, got %02h", want.char_out, got.char_out);
                fail_count++;
            end
            if (got.fg_color !== want.fg_color) begin
                $error("fg_color: expected %0d, got %0d", want.fg_color, got.fg_color);
                fail_count++;
            end
            if (got.bg_color !== want.bg_color) begin
                $error("bg_color: expected %0d, got %0d", want.bg_color, got.bg_color);
                fail_count++;
            end
            if (got.last_result !== want.last_result) begin
                $error("last_result: expected %0d, got %0d", want.last_result,
                       got.last_result);
                fail_count++;
            end
        end
    endtask

    always @(posedge aclk) begin
        if (!aresetn) begin
            parse_mode    = MODE_TEXT;
            digit_cnt     = '0;
            param_val     = '0;
            fg_now        = FG_RESET;
            bg_now        = BG_RESET;
            console_ops_q = {};
            fail_count    = 0;
        end else begin
            if (s_valid && s_ready) begin
                predict_console_ops(s_data);
            end
            if (m_valid && m_ready) begin
                check_console_op(m_data);
            end
        end
        pending = console_ops_q.size();
    end

endmodule

/* dv/tb_ansi_escape_color_parser_unit.sv */
// ----------------------------------------------------------------------------
// tb_ansi_escape_color_parser_unit
// Drives the escape parser with a short directed byte run and then with
// random escape sequences, text and noise, cut at random buffer ends, while
// both sides idle in bursts and the sink holds off once for a long stretch.
// A checker beside the parser predicts and compares every result beat.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_ansi_escape_color_parser_unit;
    import aecp_pkg::*;

    localparam int N_ITEMS     = 1150;
    localparam int TAIL_ITEMS  = 150;
    localparam int HOLD_AT     = 400;
    localparam int HOLD_CYCLES = 300;
    localparam int STUCK_LIMIT = 3000;

    logic      aclk;
    logic      aresetn;
    logic      s_valid;
    logic      s_ready;
    aecp_in_t  s_data;
    logic      m_valid;
    logic      m_ready;
    aecp_out_t m_data;

    int        fail_count;
    int        pending;
    int        bytes_sent;
    int        stuck_cycles;
    bit        tail;
    bit        sender_gaps;
    bit        sink_stalls;
    bit        hold_req;

    ansi_escape_color_parser_unit #(
        .MAX_DIGITS(15)
    ) DUT (
        .aclk   (aclk),
        .aresetn(aresetn),
        .s_valid(s_valid),
        .s_ready(s_ready),
        .s_data (s_data),
        .m_valid(m_valid),
        .m_ready(m_ready),
        .m_data (m_data)
    );

    aecp_console_checker #(
        .MAX_DIGITS(15)
    ) checker_i (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data),
        .fail_count(fail_count),
        .pending   (pending)
    );

    initial begin
        aclk = 1'b0;
        forever #4 aclk = ~aclk;
    end

    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready)) begin
            stuck_cycles <= 0;
        end else begin
            stuck_cycles <= stuck_cycles + 1;
        end
        if (stuck_cycles >= STUCK_LIMIT) begin
            $display("simulation failed");
            $finish;
        end
    end

    task automatic send_byte(input logic [7:0] b, input logic eob);
        if (!tail && sender_gaps && $urandom_range(0, 9) == 0) begin
            s_valid = 1'b0;
            repeat ($urandom_range(1, 15)) @(negedge aclk);
        end
        s_data.in_byte       = b;
        s_data.end_of_buffer = eob;
        s_valid              = 1'b1;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        @(negedge aclk);
        bytes_sent++;
        if (bytes_sent == HOLD_AT) begin
            hold_req = 1'b1;
        end
        if (bytes_sent >= N_ITEMS - TAIL_ITEMS) begin
            tail = 1'b1;
        end
    endtask

    task automatic feed_byte(input logic [7:0] b);
        send_byte(b, $urandom_range(0, 13) == 0);
    endtask

    task automatic feed_number(input int unsigned val, input int unsigned lead_zeros);
        logic [7:0]  digs[$];
        int unsigned v;
        v = val;
        do begin
            digs.push_front(8'(CH_ZERO + v % 10));
            v = v / 10;
        end while (v != 0);
        repeat (lead_zeros) digs.push_front(CH_ZERO);
        foreach (digs[i]) begin
            feed_byte(digs[i]);
        end
    endtask

    function automatic int unsigned pick_sgr_code();
        int unsigned code;
        case ($urandom_range(0, 7))
            0:       code = $urandom_range(0, 2);
            1, 2:    code = $urandom_range(29, 39);
            3, 4:    code = $urandom_range(40, 49);
            5:       code = $urandom_range(88, 99);
            6:       code = $urandom_range(0, 255);
            default: code = $urandom_range(256, 99999);
        endcase
        return code;
    endfunction

    task automatic feed_sgr_sequence();
        int unsigned sel;
        feed_byte(CH_ESC);
        feed_byte(CH_LBRACK);
        sel = $urandom_range(0, 9);
        if (sel == 1) begin
            repeat ($urandom_range(13, 17)) feed_byte(8'(CH_ZERO + $urandom_range(0, 9)));
        end else if (sel != 0) begin
            feed_number(pick_sgr_code(), ($urandom_range(0, 4) == 0) ? $urandom_range(1, 3) : 0);
        end
        case ($urandom_range(0, 19))
            0:       feed_byte(CH_NUL);
            1:       feed_byte(CH_J);
            2:       feed_byte(8'($urandom_range(0, 255)));
            default: feed_byte(CH_M);
        endcase
    endtask

    task automatic feed_clear_sequence();
        feed_byte(CH_ESC);
        feed_byte(CH_LBRACK);
        feed_number(($urandom_range(0, 3) == 0) ? $urandom_range(0, 300) : ED_ALL,
                    ($urandom_range(0, 5) == 0) ? 1 : 0);
        feed_byte(CH_J);
    endtask

    task automatic feed_random_chunk();
        int unsigned k;
        k = $urandom_range(0, 99);
        if (k < 25) begin
            repeat ($urandom_range(1, 6)) feed_byte(8'($urandom_range(1, 255)));
        end else if (k < 65) begin
            feed_sgr_sequence();
        end else if (k < 77) begin
            feed_clear_sequence();
        end else if (k < 87) begin
            feed_byte(CH_ESC);
            feed_byte(8'($urandom_range(0, 255)));
        end else if (k < 93) begin
            feed_byte(CH_NUL);
            repeat ($urandom_range(1, 4)) feed_byte(8'($urandom_range(0, 255)));
        end else begin
            repeat ($urandom_range(1, 6)) feed_byte(8'($urandom_range(0, 255)));
        end
        if ($urandom_range(0, 19) == 0) begin
            sender_gaps = !sender_gaps;
        end
    endtask

    // sink side: random stall bursts and one long hold-off
    initial begin
        m_ready = 1'b1;
        @(posedge aresetn);
        forever begin
            @(negedge aclk);
            if (hold_req) begin
                hold_req = 1'b0;
                m_ready  = 1'b0;
                repeat (HOLD_CYCLES) @(negedge aclk);
                m_ready  = 1'b1;
            end else if (!tail && sink_stalls && $urandom_range(0, 7) == 0) begin
                m_ready = 1'b0;
                repeat ($urandom_range(1, 15)) @(negedge aclk);
                m_ready = 1'b1;
            end
            if ($urandom_range(0, 63) == 0) begin
                sink_stalls = !sink_stalls;
            end
        end
    end

    initial begin
        aresetn     = 1'b0;
        s_valid     = 1'b0;
        s_data      = '0;
        bytes_sent  = 0;
        tail        = 1'b0;
        sender_gaps = 1'b1;
        sink_stalls = 1'b1;
        hold_req    = 1'b0;
        repeat (4) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;
        @(negedge aclk);

        // directed run
        send_byte(8'h41, 1'b0);
        send_byte(CH_ESC, 1'b0);
        send_byte(8'h78, 1'b0);
        send_byte(CH_ESC, 1'b0);
        send_byte(CH_LBRACK, 1'b0);
        send_byte(CH_ZERO + 8'd4, 1'b0);
        send_byte(CH_ZERO + 8'd5, 1'b0);
        send_byte(CH_M, 1'b0);
        send_byte(CH_ESC, 1'b0);
        send_byte(CH_LBRACK, 1'b0);
        send_byte(CH_ZERO + 8'd9, 1'b0);
        send_byte(CH_ZERO + 8'd6, 1'b0);
        send_byte(CH_M, 1'b0);
        send_byte(CH_ESC, 1'b0);
        send_byte(CH_LBRACK, 1'b0);
        send_byte(CH_M, 1'b0);
        send_byte(CH_ESC, 1'b0);
        send_byte(CH_LBRACK, 1'b0);
        send_byte(CH_ZERO + 8'd2, 1'b0);
        send_byte(CH_J, 1'b0);
        send_byte(CH_ESC, 1'b1);
        send_byte(CH_NUL, 1'b0);
        send_byte(8'h42, 1'b1);
        send_byte(8'hFF, 1'b1);

        while (bytes_sent < N_ITEMS) begin
            feed_random_chunk();
        end
        s_valid = 1'b0;

        while (pending != 0) @(negedge aclk);
        repeat (8) @(negedge aclk);
        if (fail_count == 0 && pending == 0) begin
            $display("simulation ok");
        end else begin
            if (pending != 0) begin
                $error("%0d expected result beats never arrived", pending);
            end
            $display("simulation failed");
        end
        $finish;
    end

endmodule
